[hw/rtl/afi_pkg.sv]
// Shared constants and types for the animation fraction interpolator.
// No dependencies; the top level, the checker and the testbench refer to this package.
`timescale 1ns / 1ps
package afi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int TIME_W   = 32;
  localparam int MS_W     = 24;
  localparam int PERIOD_W = MS_W + 1;
  localparam int REP_W    = 16;
  localparam int VAL_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_GIVEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FROM_VALUE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TO_VALUE     = 3'd6;

  typedef enum logic [1:0] {
    FRAC_ZERO,
    FRAC_ONE,
    FRAC_DIV
  } frac_case_t;

endpackage

[hw/rtl/afi_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the stall enable freezes every stage at once.
`timescale 1ns / 1ps
module afi_div_pipe #(
  parameter int DIV_W  = 32,
  parameter int DEN_W  = 25,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  num,
  input  logic [DEN_W-1:0]  rem_init,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [DIV_W-1:0]  quot,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld_s  [DIV_W+1];
  logic [DIV_W-1:0]  num_s  [DIV_W+1];
  logic [DIV_W-1:0]  quot_s [DIV_W+1];
  logic [DEN_W-1:0]  rem_s  [DIV_W+1];
  logic [SIDE_W-1:0] side_s [DIV_W+1];

  assign vld_s[0]  = in_valid;
  assign num_s[0]  = num;
  assign quot_s[0] = '0;
  assign rem_s[0]  = rem_init;
  assign side_s[0] = side_in;

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   sub;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
      trial    = {rem_s[k], num_s[k][DIV_W-1]};
      sub      = trial - {1'b0, den};
      ge       = (trial >= {1'b0, den});
      rem_next = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_s[k+1]  <= {num_s[k][DIV_W-2:0], 1'b0};
        quot_s[k+1] <= {quot_s[k][DIV_W-2:0], ge};
        rem_s[k+1]  <= rem_next;
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_valid = vld_s[DIV_W];
  assign quot      = quot_s[DIV_W];
  assign rem       = rem_s[DIV_W];
  assign side_out  = side_s[DIV_W];

endmodule

[hw/rtl/animation_fraction_interpolate_top.sv]
// Top level of the animation fraction interpolator: configuration
// registers, period fold, fraction divide and linear interpolation.
// Depends on afi_pkg and afi_div_pipe.
`timescale 1ns / 1ps
// Usage:
//   Write the seven registers through cfg_we / cfg_index / cfg_data while the
//   block is idle; a write lands at the edge where cfg_we is high, indexes
//   past the list are dropped. Time samples enter on the in channel
//   (in_valid / in_ready, payload time_now); each beat yields one result beat
//   on the out channel (progress, out_value).
//   The pipeline has FRAC_BITS + 35 register stages (51 at the default): one
//   stage for the repeat compare, 32 stages of the period-fold divider,
//   FRAC_BITS stages of the fraction divider, one multiply stage and the
//   output register; the first stage loads at the accepting edge.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   one-bit-per-stage dividers set the depth, not the rate.
//   When the receiver stalls (out_valid high, out_ready low) the whole
//   pipeline holds and in_ready drops; nothing is lost or repeated. A bubble
//   at the output lets the pipe advance regardless of out_ready.
//   Synchronous reset clears the config and valid registers; the pipe empties.
module animation_fraction_interpolate_top #(
  parameter int FRAC_BITS = afi_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [afi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [afi_pkg::TIME_W-1:0]       time_now,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [FRAC_BITS:0]               progress,
  output logic signed [afi_pkg::VAL_W-1:0] out_value
);

  localparam int MS_W     = afi_pkg::MS_W;
  localparam int PERIOD_W = afi_pkg::PERIOD_W;
  localparam int TIME_W   = afi_pkg::TIME_W;
  localparam int VAL_W    = afi_pkg::VAL_W;
  localparam int REP_W    = afi_pkg::REP_W;
  localparam int PROD_W   = VAL_W + 1 + FRAC_BITS + 2;

  // Configuration registers
  logic [MS_W-1:0]         begin_time;
  logic [MS_W-1:0]         duration;
  logic [MS_W-1:0]         end_time;
  logic                    end_given;
  logic [REP_W-1:0]        repeat_count;
  logic signed [VAL_W-1:0] from_value;
  logic signed [VAL_W-1:0] to_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_time   <= '0;
      duration     <= '0;
      end_time     <= '0;
      end_given    <= 1'b0;
      repeat_count <= '0;
      from_value   <= '0;
      to_value     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        afi_pkg::REG_BEGIN_TIME:   begin_time   <= cfg_data[MS_W-1:0];
        afi_pkg::REG_DURATION:     duration     <= cfg_data[MS_W-1:0];
        afi_pkg::REG_END_TIME:     end_time     <= cfg_data[MS_W-1:0];
        afi_pkg::REG_END_GIVEN:    end_given    <= cfg_data[0];
        afi_pkg::REG_REPEAT_COUNT: repeat_count <= cfg_data[REP_W-1:0];
        afi_pkg::REG_FROM_VALUE:   from_value   <= signed'(cfg_data[VAL_W-1:0]);
        afi_pkg::REG_TO_VALUE:     to_value     <= signed'(cfg_data[VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  // Values derived from configuration; the user must keep them steady while items are in flight; not enforced
  logic [PERIOD_W-1:0] period;
  logic                period_zero;
  logic [PERIOD_W-1:0] run_end;
  logic [VAL_W:0]      diff;

  assign run_end     = {1'b0, begin_time} + {1'b0, duration};
  assign period      = end_given ? {1'b0, end_time} : run_end;
  assign period_zero = (period == '0);
  assign diff        = {to_value[VAL_W-1], to_value} - {from_value[VAL_W-1], from_value};

  // Global advance: move whenever the output slot is empty or being taken
  logic en;
  logic o_valid;
  assign en       = !o_valid || out_ready;
  assign in_ready = en;

  // Stage A: repeat limit compare
  logic                    a_valid;
  logic [TIME_W-1:0]       a_t;
  logic                    a_hit;
  logic [REP_W+PERIOD_W-1:0] rep_limit;

  assign rep_limit = repeat_count * period;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_t   <= time_now;
      a_hit <= (repeat_count != '0) &&
               ({{(REP_W+PERIOD_W-TIME_W){1'b0}}, time_now} >= rep_limit);
    end
  end

  // Period fold: time modulo period
  logic                m_valid_fold;
  logic [TIME_W-1:0]   fold_quot;
  logic [PERIOD_W-1:0] fold_rem;
  logic [TIME_W:0]     fold_side;

  afi_div_pipe #(
    .DIV_W  (TIME_W),
    .DEN_W  (PERIOD_W),
    .SIDE_W (TIME_W + 1)
  ) u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .num       (a_t),
    .rem_init  ('0),
    .den       (period),
    .side_in   ({a_hit, a_t}),
    .out_valid (m_valid_fold),
    .quot      (fold_quot),
    .rem       (fold_rem),
    .side_out  (fold_side)
  );

  // Pick remaining time and classify the fraction
  logic [TIME_W-1:0]   remain;
  logic [MS_W-1:0]     elapsed;
  afi_pkg::frac_case_t fcase;

  always_comb begin
    if (fold_side[TIME_W]) begin
      remain = {{(TIME_W-PERIOD_W){1'b0}}, period};
    end else if (period_zero) begin
      remain = fold_side[TIME_W-1:0];
    end else begin
      remain = {{(TIME_W-PERIOD_W){1'b0}}, fold_rem};
    end
    elapsed = remain[MS_W-1:0] - begin_time;
    if (remain <= {{(TIME_W-MS_W){1'b0}}, begin_time}) begin
      fcase = afi_pkg::FRAC_ZERO;
    end else if (duration == '0 ||
                 remain >= {{(TIME_W-PERIOD_W){1'b0}}, run_end}) begin
      fcase = afi_pkg::FRAC_ONE;
    end else begin
      fcase = afi_pkg::FRAC_DIV;
    end
  end

  // Fraction divide: elapsed < duration, so start with elapsed as remainder
  logic                 f_valid;
  logic [FRAC_BITS-1:0] f_quot;
  logic [MS_W-1:0]      f_rem;
  logic [1:0]           f_side;

  afi_div_pipe #(
    .DIV_W  (FRAC_BITS),
    .DEN_W  (MS_W),
    .SIDE_W (2)
  ) u_frac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_valid_fold),
    .num       ('0),
    .rem_init  (elapsed),
    .den       (duration),
    .side_in   (fcase),
    .out_valid (f_valid),
    .quot      (f_quot),
    .rem       (f_rem),
    .side_out  (f_side)
  );

  logic [FRAC_BITS:0] frac;

  always_comb begin
    case (afi_pkg::frac_case_t'(f_side))
      afi_pkg::FRAC_ZERO: frac = '0;
      afi_pkg::FRAC_ONE:  frac = {1'b1, {FRAC_BITS{1'b0}}};
      afi_pkg::FRAC_DIV:  frac = {1'b0, f_quot};
      default:            frac = '0;
    endcase
  end

  // Multiply stage
  logic                     p_valid;
  logic [FRAC_BITS:0]       p_frac;
  logic signed [PROD_W-1:0] p_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_frac <= frac;
      p_prod <= PROD_W'(signed'(diff) * signed'({1'b0, frac}));
    end
  end

  // Output register: floor shift and add
  logic signed [PROD_W-1:0] q_full;
  assign q_full = p_prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      progress  <= p_frac;
      out_value <= from_value + signed'(q_full[VAL_W-1:0]);
    end
  end

  assign out_valid = o_valid;

endmodule

[sim/afi_checker.sv]
// Checker for the animation fraction interpolator: watches both channels,
// predicts progress and out_value from the mirrored registers, and compares.
// Depends on afi_pkg.
`timescale 1ns / 1ps
module afi_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [afi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [afi_pkg::TIME_W-1:0]       time_now,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [16:0]                      progress,
  input  logic signed [afi_pkg::VAL_W-1:0] out_value,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic [16:0]       frac;
    logic signed [31:0] value;
  } sample_t;

  logic [23:0]        start_ms, dur_ms, end_ms;
  logic               end_set;
  logic [15:0]        repeats;
  logic signed [31:0] from_v, to_v;
  sample_t            want_q[$];

  function automatic sample_t interpolate(logic [31:0] t);
    longint unsigned period, remain, frac;
    longint          diff, prod, q;
    sample_t         s;
    period = end_set ? longint'(end_ms) : longint'(start_ms) + longint'(dur_ms);
    remain = (period == 0) ? longint'(t) : longint'(t) % period;
    if (repeats != 0 && longint'(t) >= longint'(repeats) * period) remain = period;
    if (remain <= start_ms) frac = 0;
    else if (dur_ms == 0 || remain >= longint'(start_ms) + longint'(dur_ms)) frac = 65536;
    else frac = ((remain - start_ms) << 16) / dur_ms;
    if (frac > 65536) frac = 65536;
    diff = longint'(to_v) - longint'(from_v);
    prod = diff * longint'(frac);
    q = prod >>> 16;  // arithmetic shift floors toward minus infinity
    s.frac  = frac[16:0];
    s.value = 32'(longint'(from_v) + q);
    return s;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = want_q.size();

  always @(posedge clk) begin
    sample_t w;
    if (rst) begin
      start_ms <= '0; dur_ms <= '0; end_ms <= '0; end_set <= 1'b0;
      repeats <= '0; from_v <= '0; to_v <= '0;
      want_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          afi_pkg::REG_BEGIN_TIME:   start_ms <= cfg_data[23:0];
          afi_pkg::REG_DURATION:     dur_ms <= cfg_data[23:0];
          afi_pkg::REG_END_TIME:     end_ms <= cfg_data[23:0];
          afi_pkg::REG_END_GIVEN:    end_set <= cfg_data[0];
          afi_pkg::REG_REPEAT_COUNT: repeats <= cfg_data[15:0];
          afi_pkg::REG_FROM_VALUE:   from_v <= cfg_data;
          afi_pkg::REG_TO_VALUE:     to_v <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) want_q.push_back(interpolate(time_now));
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          if (progress !== w.frac) report("progress", progress, w.frac);
          if (out_value !== w.value) report("out_value", out_value, w.value);
        end
      end
    end
  end
endmodule

[sim/animation_fraction_interpolate_top_tb.sv]
// Testbench top for the animation fraction interpolator: drives registers and
// time samples with random idling, and gives the verdict.
// Depends on afi_pkg, afi_checker and the block's RTL.
`timescale 1ns / 1ps
module animation_fraction_interpolate_top_tb;

  localparam int LATENCY = 51;
  // Index one past the register list; writes to it are dropped
  localparam logic [afi_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [afi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [afi_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [afi_pkg::TIME_W-1:0]   time_now = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [16:0]         progress;
  logic signed [afi_pkg::VAL_W-1:0] out_value;
  int                  fail_count, pending;
  bit                  calm;       // no idling in the closing stretch
  int                  beats_sent;
  logic [23:0]         cur_begin, cur_dur;
  logic [15:0]         cur_rep;

  always #1 clk = ~clk;

  animation_fraction_interpolate_top dut (.*);

  afi_checker chk (.*);

  // Receiver: stall in random bursts until the closing stretch.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // Hold the write strobe; the caller drops it after the last write.
  task automatic write_reg(logic [afi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
  endtask

  // Drop valid, hold until every expected beat has come, then let the pipe drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic load(logic [23:0] b, logic [23:0] d, logic [23:0] e, bit g,
                      logic [15:0] r, logic [31:0] f, logic [31:0] t);
    drain();
    write_reg(afi_pkg::REG_BEGIN_TIME, {8'hA5, b});  // junk in the upper bits
    write_reg(afi_pkg::REG_DURATION, {8'h5A, d});
    write_reg(afi_pkg::REG_END_TIME, {8'hFF, e});
    write_reg(afi_pkg::REG_END_GIVEN, {31'h7FFF_FFFF, g});
    write_reg(afi_pkg::REG_REPEAT_COUNT, {16'hFFFF, r});
    write_reg(afi_pkg::REG_FROM_VALUE, f);
    write_reg(afi_pkg::REG_TO_VALUE, t);
    write_reg(REG_SPARE, $urandom);                  // beyond the list: dropped
    cfg_we <= 1'b0;
    cur_begin = b; cur_dur = d; cur_rep = r;
  endtask

  // Send one beat; hold valid and payload until accepted.
  task automatic send(logic [31:0] t);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    time_now <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Pick a time near the interesting points of the current setting.
  function automatic logic [31:0] pick_time();
    longint unsigned period;
    period = cur_begin + cur_dur;
    if (period == 0) period = 1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'(period) + 2);
      2: return 32'(longint'(cur_rep) * period + $urandom_range(0, 3) - 1);
      3: return 32'(cur_begin + $urandom_range(0, 3) - 1);
      4: return 32'(cur_begin + cur_dur + $urandom_range(0, 3) - 1);
      default: return $urandom_range(0, 32'(4 * period));
    endcase
  endfunction

  initial begin
    int n;
    calm = 0;
    beats_sent = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero period, fraction jumps.
    send(32'd0); send(32'hFFFF_FFFF);

    // Plain linear ramp, begin 100, duration 1000, repeat forever.
    load(24'd100, 24'd1000, 24'd0, 1'b0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(0); send(100); send(101); send(600); send(1099); send(1100); send(1101);
    send(32'hFFFF_FFFF); send(32'h8000_0000);

    // Explicit end, repeat limit reached, falling values.
    load(24'd50, 24'd200, 24'd300, 1'b1, 16'd3, 32'h7FFF_FFFF, 32'h8000_0000);
    send(899); send(900); send(901); send(250); send(32'hFFFF_FFFF);

    // Zero duration and a zero period with a repeat count, then all-ones settings.
    load(24'd10, 24'd0, 24'd0, 1'b1, 16'd5, 32'd0, 32'h0001_0000);
    send(5); send(11); send(0);
    load(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0, 16'hFFFF, 32'hFFFF_0000,
         32'h0000_FFFF);
    send(32'hFFFF_FFFF); send(32'h01FF_FFFF); send(32'h0100_0000);

    // Random phases; each pauses for a full drain when it is loaded.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) calm = 1;
      case (ph % 3)
        0: load(24'($urandom_range(0, 200)), 24'($urandom_range(0, 500)),
                24'($urandom_range(0, 800)), 1'($urandom_range(0, 1)),
                16'($urandom_range(0, 8)), $urandom, $urandom);
        1: load(24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)),
                16'($urandom), $urandom, $urandom);
        default: load(24'($urandom_range(0, 5)), 24'($urandom_range(1, 20)),
                      24'($urandom_range(0, 30)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 3)), $urandom, $urandom);
      endcase
      n = 50;
      repeat (n) send(pick_time());
    end

    drain();
    $display("covered %0d time samples over 17 register settings,", beats_sent);
    $display("including zero period, zero duration, repeat hold and full-range values");
    if (fail_count == 0) begin
      $display("** animation_fraction_interpolate_top: PASSED **");
    end else begin
      $display("** animation_fraction_interpolate_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("** animation_fraction_interpolate_top: FAILED **");
    $finish;
  end
endmodule
